// ----- rtl/core/ffa_pkg.sv -----
package ffa_pkg;

   localparam int MaxBlocksDefault = 64;
   localparam int AddrBits         = 32;
   localparam int FieldBits        = 32;
   localparam logic [FieldBits-1:0] CapacityReset = 32'd65536;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ZERO  = 2'd1,
      ST_NOFIT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init;      // reload the table from capacity
      logic load;      // capture the request
      logic prep;      // check for a zero request and range-check a free
      logic scan_rd;   // issue a read of the scan entry
      logic scan_eval; // evaluate the entry read back
      logic shift_rd;  // read an entry being moved
      logic shift_wr;  // write the moved entry
      logic commit;    // apply the final update
   } ffa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;  // scan index reached the table count
      logic hit;       // entry evaluated is the chosen one
      logic shift_end; // move sequence finished
      logic early;     // request finishes without a table change
   } ffa_stat_type;

endpackage

// ----- rtl/core/ffa_if.sv -----
interface ffa_req_if;
   import ffa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [FieldBits-1:0] size;
   logic [FieldBits-1:0] alignment;
   logic [FieldBits-1:0] offset;
   modport source (output valid, operation, size, alignment, offset, input ready);
   modport sink (input valid, operation, size, alignment, offset, output ready);
endinterface

// ----- rtl/core/ffa_rsp_if.sv -----
interface ffa_rsp_if;
   import ffa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [FieldBits-1:0] result_offset;
   logic [FieldBits-1:0] free_space;
   modport source (output valid, status, result_offset, free_space, input ready);
   modport sink (input valid, status, result_offset, free_space, output ready);
endinterface

// ----- rtl/core/ffa_ram.sv -----
module ffa_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/core/ffa_ctrl.sv -----
module ffa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                req_fire,
   input  logic                rsp_valid,
   input  ffa_pkg::ffa_stat_type stat,
   output ffa_pkg::ffa_cmd_type  cmd,
   output logic                busy
);
   import ffa_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PREP  = 8'b0000_0010,
      S_SRD   = 8'b0000_0100,
      S_SEV   = 8'b0000_1000,
      S_MRD   = 8'b0001_0000,
      S_MWR   = 8'b0010_0000,
      S_DONE  = 8'b0100_0000,
      S_WAIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Next state: scan entries, then shift the table, then commit.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_PREP;
         S_PREP: state_in = stat.early ? S_DONE : S_SRD;
         S_SRD:  state_in = stat.scan_end ? S_MRD : S_SEV;
         S_SEV: begin
            if (stat.early) state_in = S_DONE;
            else if (stat.hit) state_in = S_MRD;
            else state_in = S_SRD;
         end
         S_MRD:  state_in = stat.shift_end ? S_DONE : S_MWR;
         S_MWR:  state_in = S_MRD;
         S_DONE: state_in = S_WAIT;
         S_WAIT: if (!rsp_valid) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      cmd           = '0;
      cmd.init      = csr_write;
      cmd.load      = req_fire;
      cmd.prep      = (state_ff == S_PREP);
      cmd.scan_rd   = (state_ff == S_SRD);
      cmd.scan_eval = (state_ff == S_SEV);
      cmd.shift_rd  = (state_ff == S_MRD);
      cmd.shift_wr  = (state_ff == S_MWR);
      cmd.commit    = (state_ff == S_DONE);
   end

   assign busy = (state_ff != S_IDLE);
endmodule

// ----- rtl/core/ffa_dp.sv -----
module ffa_dp #(
   parameter int MaxBlocks = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ffa_pkg::ffa_cmd_type     cmd,
   output ffa_pkg::ffa_stat_type    stat,
   input  logic [ffa_pkg::FieldBits-1:0] csr_wdata,
   input  logic                     op,
   input  logic [ffa_pkg::FieldBits-1:0] in_size,
   input  logic [ffa_pkg::FieldBits-1:0] in_align,
   input  logic [ffa_pkg::FieldBits-1:0] in_off,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic [ffa_pkg::FieldBits-1:0] rsp_offset,
   output logic [ffa_pkg::FieldBits-1:0] rsp_free
);
   import ffa_pkg::*;

   localparam int IW = $clog2(MaxBlocks);
   localparam int CW = $clog2(MaxBlocks + 1);
   localparam int AW = AddrBits;
   localparam int XW = AddrBits + 2;
   localparam logic [CW-1:0] CntMax = CW'(MaxBlocks);

   // Extent table: offset and length stored together in one RAM word.
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [2*AW-1:0] wr_data, rd_data;

   ffa_ram #(.Width(2 * AW), .Depth(MaxBlocks)) u_tab (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [AW-1:0] rd_off, rd_len;
   assign rd_off = rd_data[2*AW-1:AW];
   assign rd_len = rd_data[AW-1:0];

   logic [AW-1:0] cap_ff, cap_in, total_ff, total_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          op_ff, op_in;
   logic [AW-1:0] size_ff, size_in, align_ff, align_in;
   logic [AW-1:0] off_ff, off_in, mask_ff, mask_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] prev_off_ff, prev_off_in, prev_len_ff, prev_len_in;
   logic          prev_ok_ff, prev_ok_in;
   logic [1:0]    st_ff, st_in;
   logic [AW-1:0] grant_ff, grant_in;
   // Planned change: action kind and moving pointer.
   logic          do_ins_ff, do_ins_in, do_rem_ff, do_rem_in;
   logic          pad_wr_ff, pad_wr_in;     // split writes the padding at hit
   logic          wr_hit_ff, wr_hit_in;     // commit writes the entry at hit
   logic [CW-1:0] mv_ff, mv_in;
   logic [CW-1:0] hit_ff, hit_in;
   logic [AW-1:0] new_off_ff, new_off_in, new_len_ff, new_len_in;   // entry written at hit
   logic [AW-1:0] ins_off_ff, ins_off_in, ins_len_ff, ins_len_in;   // entry inserted
   logic [CW-1:0] ins_at_ff, ins_at_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [AW-1:0] rsp_offset_ff, rsp_offset_in, rsp_free_ff, rsp_free_in;

   // Alignment rounded up to a power of two, as a mask of low bits.
   logic [AW-1:0] a_m1, pmask;
   always_comb begin
      a_m1 = in_align[AW-1:0] - AW'(1);
      pmask = a_m1;
      for (int s = 1; s < AW; s = s * 2) pmask = pmask | (pmask >> s);
   end

   // Per-entry candidate evaluation.
   logic [XW-1:0] aligned_x, pad_x, need_x;
   logic          fit;
   always_comb begin
      aligned_x = (XW'(rd_off) + XW'(mask_ff)) & ~XW'(mask_ff);
      pad_x     = aligned_x - XW'(rd_off);
      need_x    = pad_x + XW'(size_ff);
      fit       = need_x <= XW'(rd_len);
   end
   logic [AW-1:0] aligned, pad;
   assign aligned = aligned_x[AW-1:0];
   assign pad     = pad_x[AW-1:0];

   logic [XW-1:0] fend_x;
   assign fend_x = XW'(off_ff) + XW'(size_ff);

   // Requests that finish right after capture: zero size, zero alignment on an allocate, free out of range.
   logic prep_zero, prep_out;
   assign prep_zero = (size_ff == '0) || (op_ff == OP_ALLOC && align_ff == '0);
   assign prep_out  = (op_ff == OP_FREE) && (fend_x > XW'(cap_ff));

   logic scan_end, stat_hit, shift_end;
   assign scan_end = (idx_ff >= cnt_ff);
   assign stat_hit = cmd.scan_eval &&
                     (op_ff == OP_ALLOC ? fit : (rd_off >= off_ff));

   // Inserts walk down from the count to the insert slot, removes walk up to the end.
   always_comb begin
      if (do_ins_ff)      shift_end = (mv_ff == ins_at_ff);
      else if (do_rem_ff) shift_end = ((mv_ff + CW'(1)) >= cnt_ff);
      else                shift_end = 1'b1;
   end

   assign stat.scan_end  = scan_end;
   assign stat.early     = cmd.prep && (prep_zero || prep_out);
   assign stat.hit       = stat_hit;
   assign stat.shift_end = shift_end;

   // Merge tests for a free against the entry read and the previous one.
   logic jn_next, jn_prev;
   always_comb begin
      jn_next = (fend_x == XW'(rd_off));
      jn_prev = prev_ok_ff &&
                (XW'(prev_off_ff) + XW'(prev_len_ff) == XW'(off_ff));
   end

   // RAM port steering.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      rd_addr = idx_ff[IW-1:0];
      if (reset) begin
         wr_en   = 1'b1;
         wr_data = {AW'(0), AW'(CapacityReset)};
      end else if (cmd.init) begin
         wr_en   = 1'b1;
         wr_data = {AW'(0), csr_wdata[AW-1:0]};
      end else if (cmd.shift_rd) begin
         // Read the source of the next move.
         rd_addr = do_ins_ff ? IW'(mv_ff - CW'(1)) : IW'(mv_ff + CW'(1));
         if (shift_end && pad_wr_ff) begin
            wr_en = 1'b1; wr_addr = IW'(hit_ff); wr_data = {new_off_ff, new_len_ff};
         end
      end else if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = IW'(mv_ff);
         wr_data = rd_data;
      end else if (cmd.commit && st_ff == ST_OK) begin
         if (do_ins_ff) begin
            wr_en = 1'b1; wr_addr = IW'(ins_at_ff); wr_data = {ins_off_ff, ins_len_ff};
         end else if (wr_hit_ff) begin
            wr_en = 1'b1; wr_addr = IW'(hit_ff); wr_data = {new_off_ff, new_len_ff};
         end
      end
   end

   // Next-state logic for the request, the planned change and the response.
   always_comb begin
      cap_in        = cap_ff;
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      align_in      = align_ff;
      off_in        = off_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      prev_off_in   = prev_off_ff;
      prev_len_in   = prev_len_ff;
      prev_ok_in    = prev_ok_ff;
      st_in         = st_ff;
      grant_in      = grant_ff;
      do_ins_in     = do_ins_ff;
      do_rem_in     = do_rem_ff;
      pad_wr_in     = pad_wr_ff;
      wr_hit_in     = wr_hit_ff;
      mv_in         = mv_ff;
      hit_in        = hit_ff;
      new_off_in    = new_off_ff;
      new_len_in    = new_len_ff;
      ins_off_in    = ins_off_ff;
      ins_len_in    = ins_len_ff;
      ins_at_in     = ins_at_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_free_in   = rsp_free_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.init) begin
         cap_in   = csr_wdata[AW-1:0];
         total_in = csr_wdata[AW-1:0];
         cnt_in   = (csr_wdata[AW-1:0] != '0) ? CW'(1) : '0;
      end
      if (cmd.load) begin
         op_in      = op;
         size_in    = in_size[AW-1:0];
         align_in   = in_align[AW-1:0];
         off_in     = in_off[AW-1:0];
         mask_in    = pmask;
         idx_in     = '0;
         prev_ok_in = 1'b0;
         do_ins_in  = 1'b0;
         do_rem_in  = 1'b0;
         wr_hit_in  = 1'b0;
         pad_wr_in  = 1'b0;
         mv_in      = '0;
         grant_in   = '0;
      end
      if (cmd.prep) begin
         if (prep_zero)     st_in = ST_ZERO;
         else if (prep_out) st_in = ST_NOFIT;
         else               st_in = ST_OK;
      end
      if (cmd.scan_rd && scan_end) begin
         // End of table reached.
         if (op_ff == OP_ALLOC) begin
            st_in = ST_NOFIT;
         end else if (jn_prev) begin
            wr_hit_in = 1'b1; hit_in = idx_ff - CW'(1);
            new_off_in = prev_off_ff; new_len_in = prev_len_ff + size_ff;
         end else if (cnt_ff >= CntMax) begin
            st_in = ST_FULL;
         end else begin
            do_ins_in = 1'b1; ins_at_in = idx_ff;
            ins_off_in = off_ff; ins_len_in = size_ff;
            mv_in = cnt_ff;
         end
      end
      if (cmd.scan_eval) begin
         if (stat_hit) begin
            hit_in = idx_ff;
            if (op_ff == OP_ALLOC) begin
               grant_in = aligned;
               if (pad == '0 && size_ff == rd_len) begin
                  do_rem_in = 1'b1; mv_in = idx_ff;
               end else if (pad == '0) begin
                  wr_hit_in = 1'b1;
                  new_off_in = aligned + size_ff; new_len_in = rd_len - size_ff;
               end else if (need_x == XW'(rd_len)) begin
                  wr_hit_in = 1'b1;
                  new_off_in = rd_off; new_len_in = pad;
               end else if (cnt_ff >= CntMax) begin
                  st_in = ST_FULL;
               end else begin
                  do_ins_in = 1'b1; pad_wr_in = 1'b1;
                  new_off_in = rd_off; new_len_in = pad;
                  ins_at_in = idx_ff + CW'(1);
                  ins_off_in = aligned + size_ff;
                  ins_len_in = rd_len - pad - size_ff;
                  mv_in = cnt_ff;
               end
            end else begin
               if (jn_next && jn_prev) begin
                  wr_hit_in = 1'b1; do_rem_in = 1'b1;
                  hit_in = idx_ff - CW'(1);
                  new_off_in = prev_off_ff;
                  new_len_in = prev_len_ff + size_ff + rd_len;
                  mv_in = idx_ff;
               end else if (jn_prev) begin
                  wr_hit_in = 1'b1; hit_in = idx_ff - CW'(1);
                  new_off_in = prev_off_ff; new_len_in = prev_len_ff + size_ff;
               end else if (jn_next) begin
                  wr_hit_in = 1'b1;
                  new_off_in = off_ff; new_len_in = rd_len + size_ff;
               end else if (cnt_ff >= CntMax) begin
                  st_in = ST_FULL;
               end else begin
                  do_ins_in = 1'b1; ins_at_in = idx_ff;
                  ins_off_in = off_ff; ins_len_in = size_ff;
                  mv_in = cnt_ff;
               end
            end
         end else begin
            idx_in      = idx_ff + CW'(1);
            prev_ok_in  = 1'b1;
            prev_off_in = rd_off;
            prev_len_in = rd_len;
         end
      end
      if (cmd.shift_wr) begin
         mv_in = do_ins_ff ? mv_ff - CW'(1) : mv_ff + CW'(1);
      end
      if (cmd.commit) begin
         if (st_ff == ST_OK) begin
            if (op_ff == OP_ALLOC) total_in = total_ff - size_ff;
            else                   total_in = total_ff + size_ff;
            if (do_ins_ff)      cnt_in = cnt_ff + CW'(1);
            else if (do_rem_ff) cnt_in = cnt_ff - CW'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = st_ff;
         rsp_offset_in = (st_ff == ST_OK && op_ff == OP_ALLOC) ? grant_ff : '0;
         rsp_free_in   = total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= AW'(CapacityReset);
         total_ff     <= AW'(CapacityReset);
         cnt_ff       <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff        <= cap_in;
         total_ff      <= total_in;
         cnt_ff        <= cnt_in;
         op_ff         <= op_in;
         size_ff       <= size_in;
         align_ff      <= align_in;
         off_ff        <= off_in;
         mask_ff       <= mask_in;
         idx_ff        <= idx_in;
         prev_off_ff   <= prev_off_in;
         prev_len_ff   <= prev_len_in;
         prev_ok_ff    <= prev_ok_in;
         st_ff         <= st_in;
         grant_ff      <= grant_in;
         do_ins_ff     <= do_ins_in;
         do_rem_ff     <= do_rem_in;
         pad_wr_ff     <= pad_wr_in;
         wr_hit_ff     <= wr_hit_in;
         mv_ff         <= mv_in;
         hit_ff        <= hit_in;
         new_off_ff    <= new_off_in;
         new_len_ff    <= new_len_in;
         ins_off_ff    <= ins_off_in;
         ins_len_ff    <= ins_len_in;
         ins_at_ff     <= ins_at_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_offset = rsp_offset_ff;
   assign rsp_free   = rsp_free_ff;
endmodule

// ----- rtl/core/first_fit_free_list_allocator_core.sv -----
// Channel   Direction  Payload
// req       in         operation, size, alignment, offset
// rsp       out        status, result_offset, free_space
// csr       in         capacity (write only)
//
// After a request is taken, the core scans the table entry by entry, moves entries to open
// or close a slot, then commits the change and raises the response. Each entry read or moved
// takes a read state and then an evaluate or write state, behind the registered extent RAM read.
// A zero-size request, a zero-alignment allocate or an out-of-region free skips the scan.
// Reset is synchronous and reloads capacity 65536 as one free extent.
// The next request is taken only after the response handshake and the controller's wait state; response stalls hold it.
module first_fit_free_list_allocator_core #(
   parameter int MaxBlocks = ffa_pkg::MaxBlocksDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   ffa_req_if.sink                       req,
   ffa_rsp_if.source                     rsp,
   input  logic                          csr_write,
   input  logic [ffa_pkg::FieldBits-1:0] csr_wdata
);
   import ffa_pkg::*;

   ffa_cmd_type  cmd;
   ffa_stat_type stat;
   logic         busy, req_fire;

   assign req.ready = !busy && !rsp.valid && !csr_write;
   assign req_fire  = req.valid && req.ready;

   ffa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .csr_write(csr_write), .req_fire(req_fire),
      .rsp_valid(rsp.valid), .stat(stat), .cmd(cmd), .busy(busy)
   );

   ffa_dp #(.MaxBlocks(MaxBlocks)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .csr_wdata(csr_wdata),
      .op(req.operation), .in_size(req.size), .in_align(req.alignment),
      .in_off(req.offset), .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .rsp_status(rsp.status), .rsp_offset(rsp.result_offset),
      .rsp_free(rsp.free_space)
   );
endmodule

// ----- test/ffa_checker.sv -----
// Watches the request, response and configuration ports of the allocator,
// keeps its own copy of the free-extent table, and compares every response.
module ffa_checker
   import ffa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   ffa_req_if                   req,
   ffa_rsp_if                   rsp,
   input  logic                 csr_write,
   input  logic [FieldBits-1:0] csr_wdata,
   output int                   errors,
   output int                   pending
);

   localparam int TableDepth = MaxBlocksDefault;
   localparam logic [63:0] SpanMask = (64'd1 << AddrBits) - 64'd1;

   typedef struct {
      status_type           status;
      logic [FieldBits-1:0] granted;
      logic [FieldBits-1:0] free_space;
   } answer_type;

   answer_type  answer_q[$];
   logic [63:0] region_size;
   logic [63:0] ext_start [TableDepth];
   logic [63:0] ext_len   [TableDepth];
   int          ext_count;
   logic [63:0] free_sum;

   // Rebuild the table as one extent covering the whole region.
   function automatic void reload_table();
      for (int k = 0; k < TableDepth; k++) begin
         ext_start[k] = '0;
         ext_len[k]   = '0;
      end
      ext_len[0] = region_size;
      ext_count  = (region_size != 0) ? 1 : 0;
      free_sum   = region_size;
   endfunction

   function automatic void close_extent(int at);
      for (int k = at; k + 1 < ext_count; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_len[k]   = ext_len[k+1];
      end
      ext_count--;
   endfunction

   function automatic void open_extent(int at, logic [63:0] start, logic [63:0] len);
      for (int k = ext_count; k > at; k--) begin
         ext_start[k] = ext_start[k-1];
         ext_len[k]   = ext_len[k-1];
      end
      ext_start[at] = start;
      ext_len[at]   = len;
      ext_count++;
   endfunction

   // First-fit allocation with power-of-two rounding of the alignment.
   function automatic status_type grant_extent(logic [63:0] sz, logic [63:0] align,
                                               output logic [63:0] granted);
      logic [63:0] pow2;
      logic [63:0] start;
      logic [63:0] len;
      logic [63:0] aligned;
      logic [63:0] pad;
      pow2    = 64'd1;
      granted = '0;
      if (sz == 0 || align == 0) return ST_ZERO;
      while (pow2 < align) pow2 = pow2 << 1;
      for (int i = 0; i < ext_count; i++) begin
         start   = ext_start[i];
         len     = ext_len[i];
         aligned = (start + pow2 - 64'd1) & ~(pow2 - 64'd1);
         pad     = aligned - start;
         if (pad + sz > len) continue;
         if (pad == 0 && sz == len) begin
            close_extent(i);
         end else if (pad == 0) begin
            ext_start[i] = start + sz;
            ext_len[i]   = len - sz;
         end else if (pad + sz == len) begin
            ext_len[i] = pad;
         end else begin
            if (ext_count >= TableDepth) return ST_FULL;
            ext_len[i] = pad;
            open_extent(i + 1, aligned + sz, len - pad - sz);
         end
         free_sum = (free_sum - sz) & SpanMask;
         granted  = aligned;
         return ST_OK;
      end
      return ST_NOFIT;
   endfunction

   // Sorted insertion of a returned extent, merging with the next then previous one.
   function automatic status_type return_extent(logic [63:0] start, logic [63:0] sz);
      int idx;
      bit to_next;
      bit to_prev;
      idx = 0;
      if (sz == 0) return ST_ZERO;
      if (start + sz > region_size) return ST_NOFIT;
      while (idx < ext_count && ext_start[idx] < start) idx++;
      to_next = idx < ext_count && start + sz == ext_start[idx];
      to_prev = idx > 0 && ext_start[idx-1] + ext_len[idx-1] == start;
      if (to_next && to_prev) begin
         ext_len[idx-1] = ext_len[idx-1] + sz + ext_len[idx];
         close_extent(idx);
      end else if (to_prev) begin
         ext_len[idx-1] = ext_len[idx-1] + sz;
      end else if (to_next) begin
         ext_start[idx] = start;
         ext_len[idx]   = ext_len[idx] + sz;
      end else begin
         if (ext_count >= TableDepth) return ST_FULL;
         open_extent(idx, start, sz);
      end
      free_sum = (free_sum + sz) & SpanMask;
      return ST_OK;
   endfunction

   function automatic void flag(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 10)
         $display("mismatch on %s: expected %0h, got %0h", field, want, got);
   endfunction

   always @(posedge clock) begin
      answer_type  want;
      logic [63:0] granted;
      if (reset) begin
         region_size = 64'(CapacityReset);
         reload_table();
         answer_q.delete();
         errors = 0;
      end else begin
         // Compare an accepted response against the oldest prediction.
         if (rsp.valid && rsp.ready) begin
            if (answer_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("response with no request outstanding");
            end else begin
               want = answer_q.pop_front();
               if (rsp.status !== want.status) flag("status", 32'(rsp.status), 32'(want.status));
               if (rsp.result_offset !== want.granted)
                  flag("result_offset", rsp.result_offset, want.granted);
               if (rsp.free_space !== want.free_space)
                  flag("free_space", rsp.free_space, want.free_space);
            end
         end
         if (csr_write) begin
            region_size = 64'(csr_wdata) & SpanMask;
            reload_table();
         end
         // Predict the response of an accepted request.
         if (req.valid && req.ready) begin
            granted = '0;
            if (op_type'(req.operation) == OP_ALLOC)
               want.status = grant_extent(64'(req.size), 64'(req.alignment), granted);
            else
               want.status = return_extent(64'(req.offset), 64'(req.size));
            want.granted    = (want.status == ST_OK) ? granted[31:0] : '0;
            want.free_space = free_sum[31:0];
            answer_q = {answer_q, want};
         end
      end
      pending = answer_q.size();
   end

endmodule

// ----- test/tb_first_fit_free_list_allocator_core.sv -----
module tb_first_fit_free_list_allocator_core;
   import ffa_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_write;
   logic [FieldBits-1:0] csr_wdata;
   int                   errors;
   int                   pending;
   bit                   calm;
   logic [31:0]          region;
   logic [31:0]          live_start[$];
   logic [31:0]          live_size[$];

   ffa_req_if req ();
   ffa_rsp_if rsp ();

   first_fit_free_list_allocator_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   ffa_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response stalls, suppressed during calm stretches.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready = calm ? 1'b1 : ($urandom_range(99) >= 29);
      end
   end

   initial begin
      #20000000;
      $display("tb_first_fit_free_list_allocator_core: errors");
      $finish;
   end

   // Send one request, then wait for its response and track granted extents.
   task automatic issue(op_type op, logic [31:0] sz, logic [31:0] align, logic [31:0] start);
      if (!calm && $urandom_range(99) < 29) begin
         req.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req.valid     = 1'b1;
      req.operation = op;
      req.size      = sz;
      req.alignment = align;
      req.offset    = start;
      do @(posedge clock); while (!(req.valid && req.ready));
      @(negedge clock);
      req.valid = 1'b0;
      do @(posedge clock); while (!(rsp.valid && rsp.ready));
      if (op == OP_ALLOC && status_type'(rsp.status) == ST_OK) begin
         live_start = {live_start, rsp.result_offset};
         live_size  = {live_size, sz};
      end
      @(negedge clock);
   endtask

   // Capacity is written only once every response has come back.
   task automatic set_region(logic [31:0] value);
      wait (pending == 0);
      repeat (4) @(negedge clock);
      csr_write = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      region    = value;
      live_start.delete();
      live_size.delete();
   endtask

   // Mostly well-formed allocate and free traffic, with some noise.
   task automatic churn(int count);
      int          pick;
      int          roll;
      logic [31:0] limit;
      logic [31:0] align;
      for (int n = 0; n < count; n++) begin
         roll  = $urandom_range(99);
         limit = (region >> 3) != 0 ? (region >> 3) : 32'd1;
         if (roll < 55) begin
            align = ($urandom_range(9) == 0) ? $urandom_range(1, 1000)
                                              : 32'd1 << $urandom_range(0, 8);
            issue(OP_ALLOC, 32'd1 + $urandom_range(0, limit - 1), align, $urandom);
         end else if (roll < 85 && live_start.size() != 0) begin
            pick = $urandom_range(0, live_start.size() - 1);
            issue(OP_FREE, live_size[pick], $urandom, live_start[pick]);
            live_start.delete(pick);
            live_size.delete(pick);
         end else if (roll < 92) begin
            issue(op_type'($urandom_range(1)), $urandom, $urandom, $urandom);
         end else begin
            // Partial or overlapping free inside the region.
            issue(OP_FREE, $urandom_range(0, limit), $urandom,
                  region == 0 ? 32'd0 : $urandom_range(0, region - 1));
         end
      end
   endtask

   initial begin
      calm          = 1'b0;
      region        = CapacityReset;
      reset         = 1'b1;
      csr_write     = 1'b0;
      csr_wdata     = '0;
      req.valid     = 1'b0;
      req.operation = OP_ALLOC;
      req.size      = '0;
      req.alignment = '0;
      req.offset    = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed cases on the reset capacity.
      issue(OP_ALLOC, 32'd0, 32'd1, 32'd0);
      issue(OP_ALLOC, 32'd1, 32'd0, 32'd0);
      issue(OP_FREE, 32'd0, 32'd0, 32'd5);
      issue(OP_ALLOC, 32'd100, 32'd1, 32'hFFFF_FFFF);
      issue(OP_ALLOC, 32'd10, 32'd3, 32'd0);
      issue(OP_ALLOC, 32'd16, 32'd256, 32'd0);
      issue(OP_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
      issue(OP_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd0);
      issue(OP_ALLOC, 32'd8, 32'h8000_0000, 32'd0);
      issue(OP_FREE, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      issue(OP_FREE, 32'd2, 32'd0, 32'd65535);
      issue(OP_FREE, 32'd100, 32'd0, 32'd0);
      issue(OP_FREE, 32'd10, 32'd0, 32'd100);
      issue(OP_FREE, 32'd16, 32'd0, 32'd256);
      issue(OP_ALLOC, 32'd65536, 32'd1, 32'd0);
      issue(OP_ALLOC, 32'd1, 32'd1, 32'd0);
      issue(OP_FREE, 32'd65536, 32'd0, 32'd0);
      issue(OP_ALLOC, 32'd8, 32'd1, 32'd0);
      issue(OP_ALLOC, 32'd65520, 32'd16, 32'd0);
      issue(OP_FREE, 32'd4, 32'd0, 32'd2);

      // Fill all table entries with split extents, until no allocate fits.
      set_region(32'd128);
      calm = 1'b1;
      for (int n = 0; n < 70; n++) issue(OP_ALLOC, 32'd1, 32'd2, 32'd0);
      calm = 1'b0;
      issue(OP_FREE, 32'd1, 32'd0, 32'd120);
      issue(OP_FREE, 32'd1, 32'd0, 32'd2);
      issue(OP_FREE, 32'd1, 32'd0, 32'd4);

      set_region(32'd256);
      churn(60);
      set_region(32'd0);
      churn(20);
      set_region(32'hFFFF_FFFF);
      churn(60);
      set_region(32'd1);
      churn(15);
      set_region($urandom);
      churn(60);
      set_region(32'd65536);
      calm = 1'b1;
      churn(60);
      calm = 1'b0;
      churn(60);

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("tb_first_fit_free_list_allocator_core: clean");
      else
         $display("tb_first_fit_free_list_allocator_core: errors");
      $finish;
   end

endmodule
